// File: src/oeas_pkg.sv
// Shared types, constants and register codes for the one euro adaptive smoother.
package oeas_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int ALPHA_BITS  = 28;
	localparam int DEN_W       = 36;
	localparam int W_W         = 35;
	localparam int RATE_ITERS  = FRAC_BITS + 21;
	localparam int ALPHA_ITERS = 30;
	localparam int CNT_W       = $clog2(RATE_ITERS + 1);

	localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
	localparam logic [63:0] RATE_NUM   = 64'd1000000 << FRAC_BITS;

	localparam logic [1:0] REG_INIT_RATE  = 2'd0;
	localparam logic [1:0] REG_MIN_CUTOFF = 2'd1;
	localparam logic [1:0] REG_SPEED_GAIN = 2'd2;
	localparam logic [1:0] REG_DERIV_CUT  = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RATE_GO,
		ST_RATE_WAIT,
		ST_SPD_MUL,
		ST_SPD_USE,
		ST_W_MUL,
		ST_W_USE,
		ST_A_GO,
		ST_A_WAIT,
		ST_LP_MUL,
		ST_LP_USE,
		ST_CUT_MUL,
		ST_CUT_USE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic long_div;
	} div_req_t;

endpackage

// File: src/oeas_if.sv
// Valid/ready channel interfaces for samples and smoothed results.
interface oeas_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] sample;
	logic        [31:0] time_us;
	logic               time_valid;

	modport source (output valid, output sample, output time_us, output time_valid, input ready);
	modport sink (input valid, input sample, input time_us, input time_valid, output ready);
endinterface

interface oeas_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] smoothed;

	modport source (output valid, output smoothed, input ready);
	modport sink (input valid, input smoothed, output ready);
endinterface

// File: src/oeas_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
module oeas_div
	import oeas_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	input  logic [63:0]      num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [63:0]      quo
);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [63:0]      nq_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   diff;

	assign shifted = {rem_q, nq_q[63]};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= req.long_div ? CNT_W'(RATE_ITERS) : CNT_W'(ALPHA_ITERS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			den_q <= den;
			if (req.long_div) begin
				nq_q  <= num << (64 - RATE_ITERS);
				rem_q <= DEN_W'(num >> RATE_ITERS);
			end else begin
				nq_q  <= num << (64 - ALPHA_ITERS);
				rem_q <= DEN_W'(num >> ALPHA_ITERS);
			end
		end else if (busy_q) begin
			if (!diff[DEN_W]) begin
				rem_q <= diff[DEN_W-1:0];
				nq_q  <= {nq_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted[DEN_W-1:0];
				nq_q  <= {nq_q[62:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = nq_q;

endmodule

// File: src/one_euro_adaptive_smoother_top.sv
// Top level of the one euro adaptive smoother: registers, sequencer and datapath.
//
//   channel   dir  handshake        payload
//   samples   in   valid/ready      sample, time_us, time_valid
//   results   out  valid/ready      smoothed
//   apb       in   psel/penable     paddr[3:0], pwdata, prdata
//
// A sample with a new timestamp runs from its transfer to the next ready through
// the rate division, two alpha divisions on the shared divider, six passes
// through the shared multiplier, and the idle and output steps. Without a
// timestamp change the rate division is skipped; a zero alpha denominator skips
// that alpha division. The first sample after reset goes from the speed multiply
// straight to output. Reset is asynchronous and active low.
// A stalled result holds in its register while the next sample is taken; the
// sequencer then waits in its output step until the result drains.
module one_euro_adaptive_smoother_top
	import oeas_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	oeas_in_if.sink     samples,
	oeas_out_if.source  results,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	function automatic logic [32:0] mag33(input logic [32:0] v);
		return v[32] ? (~v + 33'd1) : v;
	endfunction

	state_t state_q, state_d;

	logic [31:0] init_rate_q, min_cut_q, gain_q, dcut_q;
	logic [31:0] cur_rate_q, prev_time_q, dt_q, cut_q;
	logic        ptk_q, primed_q, sel_q;
	logic signed [31:0] prev_raw_q, value_q, rate_est_q, sample_q, speed_q;
	logic [ALPHA_BITS:0] alpha_q;
	logic [W_W-1:0]   w_q;
	logic [DEN_W-1:0] den_q;
	logic [64:0]      prod_q;
	logic             out_valid_q;
	logic signed [31:0] out_data_q;

	logic [32:0] mul_a;
	logic [31:0] mul_b;
	div_req_t    dreq;
	logic [63:0] dnum;
	logic [DEN_W-1:0] dden;
	logic        ddone;
	logic [63:0] dquo;

	logic        cfg_wr, take_in, out_load;
	logic [32:0] spd_d, spd_mag;
	logic [65:0] spd_sum;
	logic [65:0] spd_p;
	logic signed [31:0] lp_prev, lp_s;
	logic [32:0] lp_d, lp_mag, lp_res;
	logic [65:0] lp_sum;
	logic [32:0] lp_m;
	logic [31:0] re_mag;
	logic [65:0] cut_sum;
	logic [49:0] cut_full;
	logic [65:0] w_sum;
	logic [W_W-1:0] w_new;
	logic [DEN_W-1:0] den_new;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign take_in = samples.valid && samples.ready;
	assign samples.ready  = (state_q == ST_IDLE);
	assign results.valid    = out_valid_q;
	assign results.smoothed = out_data_q;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || results.ready);

	always_comb begin
		case (paddr[3:2])
			REG_INIT_RATE:  prdata = init_rate_q;
			REG_MIN_CUTOFF: prdata = min_cut_q;
			REG_SPEED_GAIN: prdata = gain_q;
			REG_DERIV_CUT:  prdata = dcut_q;
			default:        prdata = '0;
		endcase
	end

	assign spd_d   = {sample_q[31], sample_q} - {prev_raw_q[31], prev_raw_q};
	assign spd_mag = mag33(spd_d);
	assign spd_sum = {1'b0, prod_q} + (66'd1 << (FRAC_BITS - 1));
	assign spd_p   = spd_sum >> FRAC_BITS;

	assign lp_prev = sel_q ? value_q : rate_est_q;
	assign lp_s    = sel_q ? sample_q : speed_q;
	assign lp_d    = {lp_s[31], lp_s} - {lp_prev[31], lp_prev};
	assign lp_mag  = mag33(lp_d);
	assign lp_sum  = {1'b0, prod_q} + (66'd1 << (ALPHA_BITS - 1));
	assign lp_m    = lp_sum[ALPHA_BITS+32:ALPHA_BITS];
	assign lp_res  = lp_d[32] ? ({lp_prev[31], lp_prev} - lp_m) : ({lp_prev[31], lp_prev} + lp_m);

	assign re_mag   = rate_est_q[31] ? (~rate_est_q + 32'd1) : rate_est_q;
	assign cut_sum  = {1'b0, prod_q} + (66'd1 << (FRAC_BITS - 1));
	assign cut_full = {18'd0, min_cut_q} + 50'(cut_sum >> FRAC_BITS);

	assign w_sum   = {1'b0, prod_q} + (66'd1 << 28);
	assign w_new   = W_W'(w_sum >> 29);
	assign den_new = {1'b0, w_new} + {4'd0, cur_rate_q};

	always_comb begin
		case (state_q)
			ST_SPD_MUL: begin
				mul_a = spd_mag;
				mul_b = cur_rate_q;
			end
			ST_W_MUL: begin
				mul_a = {1'b0, sel_q ? cut_q : dcut_q};
				mul_b = TWO_PI_Q29;
			end
			ST_LP_MUL: begin
				mul_a = lp_mag;
				mul_b = 32'(alpha_q);
			end
			ST_CUT_MUL: begin
				mul_a = {1'b0, re_mag};
				mul_b = gain_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		dreq.start    = (state_q == ST_RATE_GO) || (state_q == ST_A_GO);
		dreq.long_div = (state_q == ST_RATE_GO);
		if (state_q == ST_RATE_GO) begin
			dnum = RATE_NUM + {33'd0, dt_q[31:1]};
			dden = {4'd0, dt_q};
		end else begin
			dnum = {1'b0, w_q, 28'd0} + {29'd0, den_q[DEN_W-1:1]};
			dden = den_q;
		end
	end

	oeas_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.num    (dnum),
		.den    (dden),
		.done   (ddone),
		.quo    (dquo)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take_in) begin
					if (ptk_q && samples.time_valid && (samples.time_us != prev_time_q))
						state_d = ST_RATE_GO;
					else
						state_d = ST_SPD_MUL;
				end
			end
			ST_RATE_GO:   state_d = ST_RATE_WAIT;
			ST_RATE_WAIT: if (ddone) state_d = ST_SPD_MUL;
			ST_SPD_MUL:   state_d = primed_q ? ST_SPD_USE : ST_OUT;
			ST_SPD_USE:   state_d = ST_W_MUL;
			ST_W_MUL:     state_d = ST_W_USE;
			ST_W_USE:     state_d = (den_new == '0) ? ST_LP_MUL : ST_A_GO;
			ST_A_GO:      state_d = ST_A_WAIT;
			ST_A_WAIT:    if (ddone) state_d = ST_LP_MUL;
			ST_LP_MUL:    state_d = ST_LP_USE;
			ST_LP_USE:    state_d = sel_q ? ST_OUT : ST_CUT_MUL;
			ST_CUT_MUL:   state_d = ST_CUT_USE;
			ST_CUT_USE:   state_d = ST_W_MUL;
			ST_OUT:       if (out_load) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			init_rate_q <= 32'd7864320;
			min_cut_q   <= 32'd65536;
			gain_q      <= '0;
			dcut_q      <= 32'd65536;
			cur_rate_q  <= 32'd7864320;
			prev_time_q <= '0;
			ptk_q       <= 1'b0;
			primed_q    <= 1'b0;
			prev_raw_q  <= '0;
			value_q     <= '0;
			rate_est_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				case (paddr[3:2])
					REG_INIT_RATE: begin
						init_rate_q <= pwdata;
						cur_rate_q  <= pwdata;
					end
					REG_MIN_CUTOFF: min_cut_q <= pwdata;
					REG_SPEED_GAIN: gain_q    <= pwdata;
					REG_DERIV_CUT:  dcut_q    <= pwdata;
					default: ;
				endcase
			end
			if (take_in) begin
				prev_time_q <= samples.time_valid ? samples.time_us : '0;
				ptk_q       <= samples.time_valid;
			end
			if (state_q == ST_RATE_WAIT && ddone)
				cur_rate_q <= (|dquo[63:32]) ? 32'hFFFF_FFFF : dquo[31:0];
			if (state_q == ST_SPD_MUL && !primed_q) begin
				value_q    <= sample_q;
				rate_est_q <= '0;
			end
			if (state_q == ST_LP_USE) begin
				if (sel_q)
					value_q <= lp_res[31:0];
				else
					rate_est_q <= lp_res[31:0];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				prev_raw_q  <= sample_q;
				primed_q    <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * {1'b0, mul_b};
		if (take_in) begin
			sample_q <= samples.sample;
			dt_q     <= samples.time_us - prev_time_q;
		end
		if (state_q == ST_SPD_USE) begin
			sel_q <= 1'b0;
			if (spd_d[32])
				speed_q <= (spd_p > 66'h8000_0000) ? 32'sh8000_0000 : -$signed(spd_p[31:0]);
			else
				speed_q <= (spd_p > 66'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(spd_p[31:0]);
		end
		if (state_q == ST_W_USE) begin
			w_q   <= w_new;
			den_q <= den_new;
			if (den_new == '0)
				alpha_q <= '0;
		end
		if (state_q == ST_A_WAIT && ddone)
			alpha_q <= dquo[ALPHA_BITS:0];
		if (state_q == ST_CUT_USE) begin
			cut_q <= (|cut_full[49:32]) ? 32'hFFFF_FFFF : cut_full[31:0];
			sel_q <= 1'b1;
		end
		if (out_load)
			out_data_q <= value_q;
	end

endmodule

// File: src/oeas_checker.sv
// Port-level assertions for the smoother top, attached by bind.
module oeas_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_data,
	input logic        pready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("input ready too soon after transfer");

	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared while sequencer idle");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind one_euro_adaptive_smoother_top oeas_checker u_oeas_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_data  (results.smoothed),
	.pready    (pready)
);

// File: bench/tb.sv
// Self-checking testbench for the one euro adaptive smoother: directed and random samples.
module tb
	import oeas_pkg::*;
();

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	oeas_in_if  in_ch ();
	oeas_out_if out_ch ();

	one_euro_adaptive_smoother_top uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (in_ch),
		.results (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	typedef struct {
		logic [31:0] sample;
		logic [31:0] time_us;
		logic        time_valid;
		logic        typed;
		logic [31:0] smoothed;
	} stim_row_t;

	logic [63:0] cfg_init_rate;
	logic [63:0] cfg_min_cutoff;
	logic [63:0] cfg_speed_gain;
	logic [63:0] cfg_deriv_cut;
	logic [63:0] rate_hz;
	logic [63:0] last_time;
	logic        last_time_known;
	logic        primed;
	longint      last_raw;
	longint      value_est;
	longint      speed_est;

	logic [31:0] smoothed_q[$];
	int          errors;
	logic        tx_burst;
	logic        rx_burst;
	logic        took;
	int          stall_left;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic logic [63:0] alpha_of(logic [63:0] fc);
		logic [63:0] w;
		logic [63:0] den;
		w = (fc * {32'd0, TWO_PI_Q29} + (64'd1 << 28)) >> 29;
		den = w + rate_hz;
		if (den == 0)
			return 64'd0;
		return ((w << ALPHA_BITS) + den / 2) / den;
	endfunction

	function automatic longint lp_step(longint prev, longint s, logic [63:0] a);
		longint d;
		logic [63:0] mag;
		d = s - prev;
		mag = d < 0 ? 64'(-d) : 64'(d);
		mag = (mag * a + (64'd1 << (ALPHA_BITS - 1))) >> ALPHA_BITS;
		return d < 0 ? prev - longint'(mag) : prev + longint'(mag);
	endfunction

	function automatic logic [31:0] smooth_sample(logic [31:0] raw, logic [31:0] t, logic tv);
		longint s;
		longint d;
		longint spd;
		logic [63:0] dt;
		logic [63:0] r;
		logic [63:0] mag;
		logic [63:0] p;
		logic [63:0] cut;
		s = longint'($signed(raw));
		if (last_time_known && tv) begin
			dt = ({32'd0, t} - last_time) & 64'hFFFF_FFFF;
			if (dt != 0) begin
				r = ((64'd1000000 << FRAC_BITS) + dt / 2) / dt;
				rate_hz = r > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : r;
			end
		end
		last_time = tv ? {32'd0, t} : 64'd0;
		last_time_known = tv;
		if (!primed) begin
			speed_est = 0;
			value_est = s;
		end else begin
			d = s - last_raw;
			mag = d < 0 ? 64'(-d) : 64'(d);
			p = (mag * rate_hz + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
			if (d < 0)
				spd = p > 64'h8000_0000 ? -64'sh8000_0000 : -longint'(p);
			else
				spd = p > 64'h7FFF_FFFF ? 64'sh7FFF_FFFF : longint'(p);
			speed_est = lp_step(speed_est, spd, alpha_of(cfg_deriv_cut));
			mag = speed_est < 0 ? 64'(-speed_est) : 64'(speed_est);
			cut = cfg_min_cutoff
				+ ((cfg_speed_gain * mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
			if (cut > 64'hFFFF_FFFF)
				cut = 64'hFFFF_FFFF;
			value_est = lp_step(value_est, s, alpha_of(cut));
		end
		last_raw = s;
		primed = 1'b1;
		return value_est[31:0];
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_INIT_RATE: begin
				cfg_init_rate = {32'd0, val};
				rate_hz = {32'd0, val};
			end
			REG_MIN_CUTOFF: cfg_min_cutoff = {32'd0, val};
			REG_SPEED_GAIN: cfg_speed_gain = {32'd0, val};
			default: cfg_deriv_cut = {32'd0, val};
		endcase
	endtask

	task automatic send_sample(logic [31:0] raw, logic [31:0] t, logic tv,
			logic typed, logic [31:0] typed_val);
		int gap;
		logic [31:0] want;
		gap = tx_burst ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.sample <= raw;
		in_ch.time_us <= t;
		in_ch.time_valid <= tv;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		want = smooth_sample(raw, t, tv);
		if (typed && want !== typed_val) begin
			$display("%0t: table row disagrees with predictor: row %h predictor %h",
				$time, typed_val, want);
			errors++;
		end
		smoothed_q.push_back(typed ? typed_val : want);
		@(negedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (smoothed_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) begin
			took = 1'b1;
			if (smoothed_q.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %h",
					$time, out_ch.smoothed);
				errors++;
			end else begin
				if (out_ch.smoothed !== smoothed_q[0]) begin
					$display("%0t: smoothed mismatch: expected %h, actual %h",
						$time, smoothed_q[0], out_ch.smoothed);
					errors++;
				end
				void'(smoothed_q.pop_front());
			end
		end
	end

	always @(negedge clk) begin
		if (took) begin
			took = 1'b0;
			stall_left = rx_burst ? 0 : $urandom_range(0, 19);
		end
		if (stall_left > 0) begin
			out_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	initial begin
		stim_row_t   rows[$];
		logic [31:0] phase_cfg[6][4];
		logic [31:0] t;
		logic [31:0] raw;
		logic [31:0] step_max;
		logic        tv;
		int          pick;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.sample = '0;
		in_ch.time_us = '0;
		in_ch.time_valid = 1'b0;
		out_ch.ready = 1'b1;
		errors = 0;
		took = 1'b0;
		stall_left = 0;
		tx_burst = 1'b0;
		rx_burst = 1'b0;
		cfg_init_rate = 64'd7864320;
		cfg_min_cutoff = 64'd65536;
		cfg_speed_gain = 64'd0;
		cfg_deriv_cut = 64'd65536;
		rate_hz = cfg_init_rate;
		last_time = 0;
		last_time_known = 1'b0;
		primed = 1'b0;
		last_raw = 0;
		value_est = 0;
		speed_est = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		rows = '{
			'{32'h7FFF_FFFF, 32'd1000,        1'b1, 1'b1, 32'h7FFF_FFFF},
			'{32'h8000_0000, 32'd9333,        1'b1, 1'b0, 32'h0},
			'{32'h7FFF_FFFF, 32'd9333,        1'b1, 1'b0, 32'h0},
			'{32'h0000_0000, 32'd5000,        1'b1, 1'b0, 32'h0},
			'{32'h0001_0000, 32'hFFFF_FFFF,   1'b0, 1'b0, 32'h0},
			'{32'h0002_0000, 32'hFFFF_FFFF,   1'b1, 1'b0, 32'h0},
			'{32'h0003_0000, 32'h0000_0000,   1'b1, 1'b0, 32'h0},
			'{32'h0003_8000, 32'h0000_2000,   1'b1, 1'b0, 32'h0},
			'{32'hFFFF_0000, 32'h0000_6000,   1'b1, 1'b0, 32'h0},
			'{32'hFFFF_FFFF, 32'hAAAA_AAAA,   1'b1, 1'b0, 32'h0},
			'{32'h5555_5555, 32'h5555_5555,   1'b1, 1'b0, 32'h0},
			'{32'hAAAA_AAAA, 32'h5555_6000,   1'b0, 1'b0, 32'h0},
			'{32'h8000_0000, 32'h0000_0000,   1'b1, 1'b0, 32'h0},
			'{32'h7FFF_FFFF, 32'h0000_0001,   1'b1, 1'b0, 32'h0},
			'{32'h0000_0001, 32'h0000_4E20,   1'b1, 1'b0, 32'h0}
		};
		foreach (rows[i])
			send_sample(rows[i].sample, rows[i].time_us, rows[i].time_valid,
				rows[i].typed, rows[i].smoothed);
		drain();

		phase_cfg = '{
			'{32'd7864320,    32'd65536,      32'd0,          32'd65536},
			'{32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF},
			'{32'd0,          32'd0,          32'd0,          32'd0},
			'{32'd1,          32'd1,          32'h0000_8000,  32'd1},
			'{32'd7864320,    32'h0003_0000,  32'h0000_1000,  32'h0001_0000},
			'{32'd65536000,   32'h0010_0000,  32'h0010_0000,  32'h0008_0000}
		};
		t = 32'd0;
		raw = 32'd0;
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			write_reg(REG_INIT_RATE, phase_cfg[ph][0]);
			write_reg(REG_MIN_CUTOFF, phase_cfg[ph][1]);
			write_reg(REG_SPEED_GAIN, phase_cfg[ph][2]);
			write_reg(REG_DERIV_CUT, phase_cfg[ph][3]);
			for (int n = 0; n < 320; n++) begin
				if (n % 64 == 0) begin
					tx_burst = $urandom_range(0, 3) == 0;
					rx_burst = $urandom_range(0, 3) == 0;
				end
				if (n == 150)
					drain();
				pick = $urandom_range(0, 99);
				tv = 1'b1;
				if (ph == 2 && pick < 60) begin
					tv = 1'b0;
					t = $urandom;
				end else if (pick < 70) begin
					t = t + $urandom_range(500, 20000);
				end else if (pick < 78) begin
				end else if (pick < 84) begin
					t = t - $urandom_range(1, 100000);
				end else if (pick < 90) begin
					tv = 1'b0;
					t = $urandom;
				end else begin
					t = $urandom;
				end
				if ($urandom_range(0, 99) < 80) begin
					step_max = 32'd1 << $urandom_range(4, 24);
					raw = raw + $urandom_range(0, 2 * step_max) - step_max;
				end else begin
					raw = $urandom;
				end
				send_sample(raw, t, tv, 1'b0, 32'h0);
			end
		end

		drain();
		repeat (150) @(posedge clk);
		if (errors == 0 && smoothed_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
